// ===== sv/ibhq_pkg.sv =====
`default_nettype none
package ibhq_pkg;
  localparam int CAPACITY = 1024;
  localparam int KEY_W = 32;
  localparam int VTX_W = 10;
  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int CNT_W = SLOT_W + 1;
  localparam int IDX_W = CNT_W + 1;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 11;
  localparam int CAP_W = 11;
  localparam int ACT_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ORDER = 1'b1;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT   = 2'd0,
    ACT_EXTRACT  = 2'd1,
    ACT_DECREASE = 2'd2,
    ACT_INCREASE = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_EX_R0, ST_EX_R1, ST_EX_P, ST_UPD_P, ST_UPD_H,
    ST_UP_RD, ST_UP_CMP, ST_DN_RD, ST_DN_C1, ST_DN_C2, ST_DN_CMP,
    ST_PLACE, ST_FIN_RD, ST_FIN
  } state_t;

  typedef struct packed {
    logic [VTX_W-1:0] v;
    logic [KEY_W-1:0] k;
  } entry_t;

  typedef struct packed {
    logic              we;
    logic [VTX_W-1:0]  addr;
    logic [SLOT_W-1:0] data;
  } pos_wr_t;

  function automatic logic misordered(input logic order, input logic [KEY_W-1:0] p,
                                      input logic [KEY_W-1:0] c);
    misordered = order ? (p < c) : (p > c);
  endfunction
endpackage
`default_nettype wire

// ===== sv/ibhq_if.sv =====
`default_nettype none
interface ibhq_item_if;
  logic                          valid;
  logic                          ready;
  logic [ibhq_pkg::ACT_W-1:0]    action;
  logic [ibhq_pkg::VTX_W-1:0]    vertex;
  logic [ibhq_pkg::KEY_W-1:0]    key;
  modport source (output valid, action, vertex, key, input ready);
  modport sink (input valid, action, vertex, key, output ready);
endinterface

interface ibhq_result_if;
  logic                          valid;
  logic                          ready;
  logic [ibhq_pkg::VTX_W-1:0]    out_vertex;
  logic [ibhq_pkg::KEY_W-1:0]    out_key;
  logic                          valid_res;
  logic [ibhq_pkg::SLOT_W-1:0]   heap_slot;
  logic [ibhq_pkg::CNT_W-1:0]    entry_count;
  logic                          is_empty;
  logic                          overflow;
  modport source (output valid, out_vertex, out_key, valid_res, heap_slot, entry_count,
                  is_empty, overflow, input ready);
  modport sink (input valid, out_vertex, out_key, valid_res, heap_slot, entry_count,
                is_empty, overflow, output ready);
endinterface

interface ibhq_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [ibhq_pkg::CFG_IDX_W-1:0]    index;
  logic [ibhq_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== sv/ibhq_ram.sv =====
`default_nettype none
module ibhq_ram #(
  parameter int AW = 10,
  parameter int DW = 32
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);
  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== sv/indexed_binary_heap_queue.sv =====
// channel | dir | beat
// req     | in  | action, vertex, key
// rsp     | out | out_vertex, out_key, valid_res, heap_slot, entry_count, is_empty, overflow
// cfg     | in  | index, data (0 capacity_in_use, 1 heap_order)
// One item at a time; each tree level takes UP_RD, UP_CMP going up and DN_RD, DN_C1,
// DN_C2 (with a right child), DN_CMP going down; the heap RAM has a single read port.
// Reset clears count and control; RAM contents are not cleared.
// A finished result sits in the output register while the next beat is taken.
`default_nettype none
module indexed_binary_heap_queue (
  input wire logic clk,
  input wire logic rst,
  ibhq_item_if.sink     req,
  ibhq_result_if.source rsp,
  ibhq_cfg_if.sink      cfg
);
  localparam int SW = ibhq_pkg::SLOT_W;
  localparam int CW = ibhq_pkg::CNT_W;
  localparam int IW = ibhq_pkg::IDX_W;

  ibhq_pkg::state_t state, state_next;
  logic [ibhq_pkg::CAP_W-1:0] cap;
  logic order;
  logic [CW-1:0] cnt, cnt_next;
  logic [SW-1:0] s, s_next, ci, ci_next;
  ibhq_pkg::entry_t mv, mv_next, c, c_next;
  ibhq_pkg::action_t act;
  logic [ibhq_pkg::VTX_W-1:0] vtx, resv, resv_next;
  logic [ibhq_pkg::KEY_W-1:0] key;
  logic ok, ok_next, ovf, ovf_next;
  ibhq_pkg::pos_wr_t pend, pend_next;

  logic h_we;
  logic [SW-1:0] h_waddr, h_raddr;
  ibhq_pkg::entry_t h_wdata, h_rdata;
  ibhq_pkg::pos_wr_t p_wr;
  logic [ibhq_pkg::VTX_W-1:0] p_raddr;
  logic [SW-1:0] p_rdata;

  logic in_acc, out_free;
  logic [CW-1:0] capc;
  logic [IW-1:0] c1, c2;
  logic [SW-1:0] last;

  ibhq_ram #(.AW(SW), .DW($bits(ibhq_pkg::entry_t))) u_heap (
    .clk, .we(h_we), .waddr(h_waddr), .wdata(h_wdata), .raddr(h_raddr), .rdata(h_rdata)
  );

  ibhq_ram #(.AW(ibhq_pkg::VTX_W), .DW(SW)) u_pos (
    .clk, .we(p_wr.we), .waddr(p_wr.addr), .wdata(p_wr.data), .raddr(p_raddr),
    .rdata(p_rdata)
  );

  assign req.ready = (state == ibhq_pkg::ST_IDLE);
  assign cfg.ready = 1'b1;
  assign in_acc = req.valid && req.ready;
  assign out_free = !rsp.valid || rsp.ready;
  assign capc = (cap > CW'(ibhq_pkg::CAPACITY)) ? CW'(ibhq_pkg::CAPACITY) : CW'(cap);
  assign c1 = IW'({s, 1'b1});
  assign c2 = c1 + IW'(1);
  assign last = SW'(cnt - CW'(1));

  always_comb begin
    state_next = state;
    unique case (state)
      ibhq_pkg::ST_IDLE: begin
        if (in_acc) begin
          unique case (ibhq_pkg::action_t'(req.action))
            ibhq_pkg::ACT_INSERT:
              state_next = (cnt >= capc) ? ibhq_pkg::ST_FIN_RD : ibhq_pkg::ST_UP_RD;
            ibhq_pkg::ACT_EXTRACT:
              state_next = (cnt == '0) ? ibhq_pkg::ST_FIN_RD : ibhq_pkg::ST_EX_R0;
            default: state_next = ibhq_pkg::ST_UPD_P;
          endcase
        end
      end
      ibhq_pkg::ST_EX_R0: state_next = ibhq_pkg::ST_EX_R1;
      ibhq_pkg::ST_EX_R1: state_next = ibhq_pkg::ST_EX_P;
      ibhq_pkg::ST_EX_P: state_next = ibhq_pkg::ST_DN_RD;
      ibhq_pkg::ST_UPD_P:
        state_next = (CW'(p_rdata) < cnt) ? ibhq_pkg::ST_UPD_H : ibhq_pkg::ST_FIN_RD;
      ibhq_pkg::ST_UPD_H: begin
        if (h_rdata.v != vtx) begin
          state_next = ibhq_pkg::ST_FIN_RD;
        end else if (act == ibhq_pkg::ACT_DECREASE) begin
          state_next = ibhq_pkg::ST_UP_RD;
        end else begin
          state_next = ibhq_pkg::ST_DN_RD;
        end
      end
      ibhq_pkg::ST_UP_RD:
        state_next = (s != '0) ? ibhq_pkg::ST_UP_CMP : ibhq_pkg::ST_PLACE;
      ibhq_pkg::ST_UP_CMP:
        state_next = ibhq_pkg::misordered(order, h_rdata.k, mv.k) ? ibhq_pkg::ST_UP_RD
                                                                   : ibhq_pkg::ST_PLACE;
      ibhq_pkg::ST_DN_RD:
        state_next = (c1 < IW'(cnt)) ? ibhq_pkg::ST_DN_C1 : ibhq_pkg::ST_PLACE;
      ibhq_pkg::ST_DN_C1:
        state_next = (c2 < IW'(cnt)) ? ibhq_pkg::ST_DN_C2 : ibhq_pkg::ST_DN_CMP;
      ibhq_pkg::ST_DN_C2: state_next = ibhq_pkg::ST_DN_CMP;
      ibhq_pkg::ST_DN_CMP:
        state_next = ibhq_pkg::misordered(order, mv.k, c.k) ? ibhq_pkg::ST_DN_RD
                                                             : ibhq_pkg::ST_PLACE;
      ibhq_pkg::ST_PLACE: state_next = ibhq_pkg::ST_FIN_RD;
      ibhq_pkg::ST_FIN_RD: state_next = ibhq_pkg::ST_FIN;
      ibhq_pkg::ST_FIN: if (out_free) state_next = ibhq_pkg::ST_IDLE;
      default: state_next = ibhq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_next = cnt;
    s_next = s;
    ci_next = ci;
    mv_next = mv;
    c_next = c;
    resv_next = resv;
    ok_next = ok;
    ovf_next = ovf;
    pend_next = pend;
    h_we = 1'b0;
    h_waddr = s;
    h_wdata = mv;
    h_raddr = '0;
    p_wr = pend;
    p_raddr = vtx;
    unique case (state)
      ibhq_pkg::ST_IDLE: begin
        p_wr.we = 1'b0;
        pend_next.we = 1'b0;
        p_raddr = req.vertex;
        if (in_acc) begin
          ok_next = 1'b0;
          ovf_next = 1'b0;
          resv_next = req.vertex;
          mv_next = '{v: req.vertex, k: req.key};
          if (ibhq_pkg::action_t'(req.action) == ibhq_pkg::ACT_INSERT) begin
            if (cnt >= capc) begin
              ovf_next = 1'b1;
            end else begin
              p_wr = '{we: 1'b1, addr: req.vertex, data: SW'(cnt)};
              s_next = SW'(cnt);
              cnt_next = cnt + CW'(1);
              ok_next = 1'b1;
            end
          end
        end
      end
      ibhq_pkg::ST_EX_R0: begin
        p_wr.we = 1'b0;
        resv_next = h_rdata.v;
        c_next = h_rdata;
        h_raddr = last;
      end
      ibhq_pkg::ST_EX_R1: begin
        mv_next = h_rdata;
        p_wr = '{we: 1'b1, addr: h_rdata.v, data: '0};
      end
      ibhq_pkg::ST_EX_P: begin
        p_wr = '{we: 1'b1, addr: c.v, data: last};
        cnt_next = cnt - CW'(1);
        s_next = '0;
        ok_next = 1'b1;
      end
      ibhq_pkg::ST_UPD_P: begin
        p_wr.we = 1'b0;
        s_next = p_rdata;
        h_raddr = p_rdata;
      end
      ibhq_pkg::ST_UPD_H: begin
        p_wr.we = 1'b0;
        ok_next = (h_rdata.v == vtx);
        mv_next = '{v: vtx, k: key};
      end
      ibhq_pkg::ST_UP_RD: begin
        pend_next.we = 1'b0;
        ci_next = SW'((s - SW'(1)) >> 1);
        h_raddr = SW'((s - SW'(1)) >> 1);
      end
      ibhq_pkg::ST_UP_CMP: begin
        p_wr.we = 1'b0;
        if (ibhq_pkg::misordered(order, h_rdata.k, mv.k)) begin
          h_we = 1'b1;
          h_wdata = h_rdata;
          p_wr = '{we: 1'b1, addr: mv.v, data: ci};
          pend_next = '{we: 1'b1, addr: h_rdata.v, data: s};
          s_next = ci;
        end
      end
      ibhq_pkg::ST_DN_RD: begin
        pend_next.we = 1'b0;
        h_raddr = c1[SW-1:0];
      end
      ibhq_pkg::ST_DN_C1: begin
        p_wr.we = 1'b0;
        c_next = h_rdata;
        ci_next = c1[SW-1:0];
        h_raddr = c2[SW-1:0];
      end
      ibhq_pkg::ST_DN_C2: begin
        p_wr.we = 1'b0;
        if (ibhq_pkg::misordered(order, c.k, h_rdata.k)) begin
          c_next = h_rdata;
          ci_next = c2[SW-1:0];
        end
      end
      ibhq_pkg::ST_DN_CMP: begin
        p_wr.we = 1'b0;
        if (ibhq_pkg::misordered(order, mv.k, c.k)) begin
          h_we = 1'b1;
          h_wdata = c;
          p_wr = '{we: 1'b1, addr: c.v, data: s};
          pend_next = '{we: 1'b1, addr: mv.v, data: ci};
          s_next = ci;
        end
      end
      ibhq_pkg::ST_PLACE: begin
        p_wr.we = 1'b0;
        h_we = 1'b1;
      end
      ibhq_pkg::ST_FIN_RD: p_wr.we = 1'b0;
      ibhq_pkg::ST_FIN: p_wr.we = 1'b0;
      default: p_wr.we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ibhq_pkg::ST_IDLE;
      cnt <= '0;
      cap <= ibhq_pkg::CAP_W'(ibhq_pkg::CAPACITY);
      order <= 1'b0;
      pend <= '0;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      pend <= pend_next;
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == ibhq_pkg::REG_CAPACITY) begin
          cap <= ibhq_pkg::CAP_W'(cfg.data);
        end else if (cfg.index == ibhq_pkg::REG_ORDER) begin
          order <= cfg.data[0];
        end
      end
      if (state == ibhq_pkg::ST_FIN && out_free) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // on extract, key holds the root key from here on
  always_ff @(posedge clk) begin
    s <= s_next;
    ci <= ci_next;
    mv <= mv_next;
    c <= c_next;
    resv <= resv_next;
    ok <= ok_next;
    ovf <= ovf_next;
    if (in_acc) begin
      act <= ibhq_pkg::action_t'(req.action);
      vtx <= req.vertex;
      key <= req.key;
    end else if (state == ibhq_pkg::ST_EX_R0) begin
      key <= h_rdata.k;
    end
    if (state == ibhq_pkg::ST_FIN && out_free) begin
      rsp.out_vertex <= ok ? resv : vtx;
      rsp.out_key <= ok ? key : '0;
      rsp.valid_res <= ok;
      rsp.heap_slot <= p_rdata;
      rsp.entry_count <= cnt;
      rsp.is_empty <= (cnt == '0);
      rsp.overflow <= ovf;
    end
  end

  a_cnt_max: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(ibhq_pkg::CAPACITY)) else $error("count above capacity");
  a_ins_inc: assert property (@(posedge clk) disable iff (rst)
    in_acc && req.action == ibhq_pkg::ACT_INSERT && cnt < capc |=> cnt == $past(cnt) + CW'(1))
    else $error("insert did not grow count");
  a_key_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.valid_res |-> rsp.out_key == '0) else $error("key on failed beat");
  a_empty: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.is_empty == (rsp.entry_count == '0)) else $error("empty flag mismatch");
endmodule
`default_nettype wire
